// ----- design/blpg_pkg.sv -----
`timescale 1ns / 1ps

package blpg_pkg;

    localparam int COL_W   = 6;
    localparam int ROW_W   = 5;
    localparam int GLYPH_W = 8;
    localparam int ERR_W   = 8;

    // input tdata layout
    localparam int IN_DATA_W = 32;
    localparam int OUT_DATA_W = 24;

    // command queue between front and walker
    localparam int CQ_DEPTH = 2;
    localparam int CQ_AW    = 1;

    typedef struct packed {
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   tcol;
        logic [ROW_W-1:0]   trow;
        logic [COL_W-1:0]   span_x;
        logic [ROW_W-1:0]   span_y;
        logic               step_left;
        logic               step_up;
        logic [ERR_W-1:0]   err;
        logic [GLYPH_W-1:0] glyph;
    } line_cmd_t;

    typedef struct packed {
        logic push;
        logic full;
    } cq_wr_ctl_t;

    typedef enum logic {
        WALK_IDLE,
        WALK_RUN
    } walk_state_t;

endpackage

// ----- design/blpg_front.sv -----
`timescale 1ns / 1ps

module blpg_front #(
    parameter int GRID_COLS = 64,
    parameter int GRID_ROWS = 32
) (
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [blpg_pkg::IN_DATA_W-1:0] s_axis_tdata,
    input  logic                          cq_full,
    output blpg_pkg::cq_wr_ctl_t          cq_ctl,
    output blpg_pkg::line_cmd_t           cmd
);
    import blpg_pkg::*;

    localparam logic [COL_W-1:0] COL_LIM = COL_W'((GRID_COLS - 1 > 63) ? 63 : GRID_COLS - 1);
    localparam logic [ROW_W-1:0] ROW_LIM = ROW_W'((GRID_ROWS - 1 > 31) ? 31 : GRID_ROWS - 1);

    logic [COL_W-1:0] xs_raw;
    logic [ROW_W-1:0] ys_raw;
    logic [COL_W-1:0] xe_raw;
    logic [ROW_W-1:0] ye_raw;
    logic [COL_W-1:0] xs;
    logic [ROW_W-1:0] ys;
    logic [COL_W-1:0] xe;
    logic [ROW_W-1:0] ye;
    logic             left;
    logic             up;
    logic [COL_W-1:0] sx;
    logic [ROW_W-1:0] sy;

    assign xs_raw = s_axis_tdata[5:0];
    assign ys_raw = s_axis_tdata[10:6];
    assign xe_raw = s_axis_tdata[16:11];
    assign ye_raw = s_axis_tdata[21:17];

    // endpoints saturate to the grid so no point is dropped
    assign xs = (xs_raw > COL_LIM) ? COL_LIM : xs_raw;
    assign ys = (ys_raw > ROW_LIM) ? ROW_LIM : ys_raw;
    assign xe = (xe_raw > COL_LIM) ? COL_LIM : xe_raw;
    assign ye = (ye_raw > ROW_LIM) ? ROW_LIM : ye_raw;

    // equal coordinates count as "toward lower"; the span is zero then
    assign left = !(xs < xe);
    assign up   = !(ys < ye);
    assign sx   = left ? (xs - xe) : (xe - xs);
    assign sy   = up ? (ys - ye) : (ye - ys);

    always_comb
    begin
        cmd.col       = xs;
        cmd.row       = ys;
        cmd.tcol      = xe;
        cmd.trow      = ye;
        cmd.span_x    = sx;
        cmd.span_y    = sy;
        cmd.step_left = left;
        cmd.step_up   = up;
        cmd.err       = {2'b00, sx} - {3'b000, sy};
        cmd.glyph     = s_axis_tdata[29:22];
    end

    assign s_axis_tready = !cq_full;
    assign cq_ctl.push   = s_axis_tvalid && !cq_full;
    assign cq_ctl.full   = cq_full;

endmodule

// ----- design/blpg_cmd_queue.sv -----
`timescale 1ns / 1ps

module blpg_cmd_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  blpg_pkg::cq_wr_ctl_t wr_ctl,
    input  blpg_pkg::line_cmd_t  wr_cmd,
    output logic                 full,
    output logic                 not_empty,
    input  logic                 pop,
    output blpg_pkg::line_cmd_t  rd_cmd
);
    import blpg_pkg::*;

    line_cmd_t        mem [CQ_DEPTH];
    logic [CQ_AW-1:0] wr_ptr_reg;
    logic [CQ_AW-1:0] wr_ptr_next;
    logic [CQ_AW-1:0] rd_ptr_reg;
    logic [CQ_AW-1:0] rd_ptr_next;
    logic [CQ_AW:0]   count_reg;
    logic [CQ_AW:0]   count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == (CQ_AW+1)'(CQ_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = wr_ctl.push && !wr_ctl.full;
    assign do_pop    = pop && not_empty;
    assign rd_cmd    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + (do_push ? CQ_AW'(1) : CQ_AW'(0));
        rd_ptr_next = rd_ptr_reg + (do_pop ? CQ_AW'(1) : CQ_AW'(0));
        count_next  = count_reg + (do_push ? (CQ_AW+1)'(1) : (CQ_AW+1)'(0))
                                - (do_pop ? (CQ_AW+1)'(1) : (CQ_AW+1)'(0));
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- design/blpg_walker.sv -----
`timescale 1ns / 1ps

module blpg_walker #(
    parameter int GRID_COLS = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cq_not_empty,
    input  blpg_pkg::line_cmd_t             cq_cmd,
    output logic                            cq_pop,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [blpg_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                            m_axis_tuser,
    output logic                            m_axis_tlast
);
    import blpg_pkg::*;

    walk_state_t        state_reg;
    walk_state_t        state_next;
    line_cmd_t          cur_reg;
    line_cmd_t          cur_next;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [COL_W-1:0]   out_col_reg;
    logic [COL_W-1:0]   out_col_next;
    logic [ROW_W-1:0]   out_row_reg;
    logic [ROW_W-1:0]   out_row_next;
    logic [GLYPH_W-1:0] out_glyph_reg;
    logic [GLYPH_W-1:0] out_glyph_next;
    logic               out_right_reg;
    logic               out_right_next;
    logic               out_last_reg;
    logic               out_last_next;

    logic               slot_free;
    logic               done;
    logic signed [ERR_W:0] e2;
    logic signed [ERR_W:0] neg_sy;
    logic signed [ERR_W:0] pos_sx;
    logic               move_x;
    logic               move_y;
    logic [ERR_W:0]     err_upd;

    assign slot_free = !out_valid_reg || m_axis_tready;
    assign done      = (cur_reg.col == cur_reg.tcol) && (cur_reg.row == cur_reg.trow);

    assign e2     = signed'({cur_reg.err, 1'b0});
    assign pos_sx = signed'({{(ERR_W+1-COL_W){1'b0}}, cur_reg.span_x});
    assign neg_sy = -signed'({{(ERR_W+1-ROW_W){1'b0}}, cur_reg.span_y});
    assign move_x = e2 > neg_sy;
    assign move_y = e2 < pos_sx;

    always_comb
    begin
        err_upd = {cur_reg.err[ERR_W-1], cur_reg.err};
        if (move_x)
        begin
            err_upd = err_upd - {{(ERR_W+1-ROW_W){1'b0}}, cur_reg.span_y};
        end
        if (move_y)
        begin
            err_upd = err_upd + {{(ERR_W+1-COL_W){1'b0}}, cur_reg.span_x};
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        cq_pop         = 1'b0;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_col_next   = out_col_reg;
        out_row_next   = out_row_reg;
        out_glyph_next = out_glyph_reg;
        out_right_next = out_right_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            WALK_IDLE:
            begin
                if (cq_not_empty)
                begin
                    cq_pop     = 1'b1;
                    cur_next   = cq_cmd;
                    state_next = WALK_RUN;
                end
            end
            WALK_RUN:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_col_next   = cur_reg.col;
                    out_row_next   = cur_reg.row;
                    out_glyph_next = cur_reg.glyph;
                    // double-width cell, except in the last grid column
                    out_right_next = ({1'b0, cur_reg.col} + (COL_W+1)'(1))
                                     < (COL_W+1)'(GRID_COLS);
                    out_last_next  = done;
                    if (done)
                    begin
                        state_next = WALK_IDLE;
                    end
                    else
                    begin
                        if (move_x)
                        begin
                            cur_next.col = cur_reg.step_left ? cur_reg.col - COL_W'(1)
                                                             : cur_reg.col + COL_W'(1);
                        end
                        if (move_y)
                        begin
                            cur_next.row = cur_reg.step_up ? cur_reg.row - ROW_W'(1)
                                                           : cur_reg.row + ROW_W'(1);
                        end
                        cur_next.err = err_upd[ERR_W-1:0];
                    end
                end
            end
            default:
            begin
                state_next = WALK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= WALK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        out_col_reg   <= out_col_next;
        out_row_reg   <= out_row_next;
        out_glyph_reg <= out_glyph_next;
        out_right_reg <= out_right_next;
        out_last_reg  <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b00000, out_glyph_reg, out_row_reg, out_col_reg};
    assign m_axis_tuser  = out_right_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

// ----- design/bresenham_line_point_generator_top.sv -----
`timescale 1ns / 1ps

// Channel  Dir  Signals                        Contents (lowest bit up)
// s_axis   in   tvalid tready tdata[31:0]      x_start[5:0] y_start[10:6] x_end[16:11]
//                                              y_end[21:17] glyph[29:22]
// m_axis   out  tvalid tready tdata[23:0]      cell_col[5:0] cell_row[10:6] cell_glyph[18:11]
//               tuser tlast                    tuser = also_right, tlast = last_point
//
// A line of max(|dx|,|dy|)+1 points leaves the walker's error/coordinate register loop at
// one point per cycle when not stalled; its idle state then pops the next queued request.
// Up to two requests wait in the queue, so the input keeps accepting while a line walks.
// Output stalls hold the walker in place; nothing is lost or repeated.
// Reset (rst_n low, asynchronous) empties the queue and the output register.

module bresenham_line_point_generator_top #(
    parameter int GRID_COLS = 64,
    parameter int GRID_ROWS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [blpg_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // x_start y_start x_end y_end glyph
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [blpg_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // cell_col cell_row cell_glyph
    output logic                            m_axis_tuser,  // also_right
    output logic                            m_axis_tlast   // last_point
);
    import blpg_pkg::*;

    cq_wr_ctl_t wr_ctl;
    line_cmd_t  front_cmd;
    line_cmd_t  head_cmd;
    logic       cq_full;
    logic       cq_not_empty;
    logic       cq_pop;

    blpg_front #(
        .GRID_COLS (GRID_COLS),
        .GRID_ROWS (GRID_ROWS)
    ) u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .cq_full       (cq_full),
        .cq_ctl        (wr_ctl),
        .cmd           (front_cmd)
    );

    blpg_cmd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_ctl    (wr_ctl),
        .wr_cmd    (front_cmd),
        .full      (cq_full),
        .not_empty (cq_not_empty),
        .pop       (cq_pop),
        .rd_cmd    (head_cmd)
    );

    blpg_walker #(
        .GRID_COLS (GRID_COLS)
    ) u_walker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cq_not_empty  (cq_not_empty),
        .cq_cmd        (head_cmd),
        .cq_pop        (cq_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ----- design/blpg_checker.sv -----
`timescale 1ns / 1ps

module blpg_checker #(
    parameter int GRID_COLS = 64,
    parameter int GRID_ROWS = 32
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [blpg_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic                            m_axis_tuser,
    input logic                            m_axis_tlast
);
    import blpg_pkg::*;

    localparam logic [COL_W-1:0] COL_LIM = COL_W'((GRID_COLS - 1 > 63) ? 63 : GRID_COLS - 1);
    localparam logic [ROW_W-1:0] ROW_LIM = ROW_W'((GRID_ROWS - 1 > 31) ? 31 : GRID_ROWS - 1);

    // a stalled point is held as is
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("output request changed while stalled");

    a_on_grid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[5:0] <= COL_LIM) && (m_axis_tdata[10:6] <= ROW_LIM))
        else $error("point off the grid");

    a_right_edge: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser == (m_axis_tdata[5:0] != COL_W'(GRID_COLS - 1))))
        else $error("also_right wrong for column");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[23:19] == 5'b00000))
        else $error("tdata padding not zero");

endmodule

bind bresenham_line_point_generator_top blpg_checker #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS)
) u_blpg_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    import blpg_pkg::*;

    localparam int GRID_COLS = 64;
    localparam int GRID_ROWS = 32;
    localparam int COL_LIM   = (GRID_COLS - 1 > 63) ? 63 : GRID_COLS - 1;
    localparam int ROW_LIM   = (GRID_ROWS - 1 > 31) ? 31 : GRID_ROWS - 1;

    typedef struct {
        logic [COL_W-1:0]   xs;
        logic [ROW_W-1:0]   ys;
        logic [COL_W-1:0]   xe;
        logic [ROW_W-1:0]   ye;
        logic [GLYPH_W-1:0] glyph;
    } line_req_t;

    typedef struct {
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic [GLYPH_W-1:0] glyph;
        logic               right;
        logic               last;
    } cell_write_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;

    line_req_t   line_requests[$];
    cell_write_t expected_points[$];
    int          lines_offered;
    int          lines_taken;
    int          errors;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          phase;
    logic        rx_blocked;

    bresenham_line_point_generator_top #(
        .GRID_COLS(GRID_COLS),
        .GRID_ROWS(GRID_ROWS)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // All-octant Bresenham walk; pushes every point of the line in walk order.
    function automatic void trace_line(input line_req_t req);
        logic [COL_W-1:0]        c;
        logic [COL_W-1:0]        tc;
        logic [COL_W-1:0]        sx;
        logic [ROW_W-1:0]        r;
        logic [ROW_W-1:0]        tr;
        logic [ROW_W-1:0]        sy;
        logic                    left;
        logic                    up;
        logic signed [ERR_W-1:0] err;
        int                      e;
        int                      e2;
        cell_write_t             pt;
        // endpoints saturate to the grid
        c    = (int'(req.xs) > COL_LIM) ? COL_W'(COL_LIM) : req.xs;
        r    = (int'(req.ys) > ROW_LIM) ? ROW_W'(ROW_LIM) : req.ys;
        tc   = (int'(req.xe) > COL_LIM) ? COL_W'(COL_LIM) : req.xe;
        tr   = (int'(req.ye) > ROW_LIM) ? ROW_W'(ROW_LIM) : req.ye;
        left = !(c < tc);
        up   = !(r < tr);
        sx   = left ? c - tc : tc - c;
        sy   = up ? r - tr : tr - r;
        e    = int'(sx) - int'(sy);
        err  = e[ERR_W-1:0];
        for (int n = 0; n < 64; n++)
        begin
            pt.col   = c;
            pt.row   = r;
            pt.glyph = req.glyph;
            pt.right = (int'(c) + 1 < GRID_COLS);
            pt.last  = (c == tc) && (r == tr);
            expected_points.push_back(pt);
            if (pt.last)
                break;
            e  = err;
            e2 = e * 2;
            if (e2 > -int'(sy))
            begin
                e = e - int'(sy);
                c = left ? c - 1'b1 : c + 1'b1;
            end
            if (e2 < int'(sx))
            begin
                e = e + int'(sx);
                r = up ? r - 1'b1 : r + 1'b1;
            end
            err = e[ERR_W-1:0];
        end
    endfunction

    task automatic add_line(input int xs, input int ys, input int xe, input int ye,
                            input int g);
        line_req_t req;
        req.xs    = xs[COL_W-1:0];
        req.ys    = ys[ROW_W-1:0];
        req.xe    = xe[COL_W-1:0];
        req.ye    = ye[ROW_W-1:0];
        req.glyph = g[GLYPH_W-1:0];
        line_requests.push_back(req);
    endtask

    task automatic add_random_lines(input int count);
        int xs;
        int ys;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < 70)
                add_line($urandom_range(63), $urandom_range(31), $urandom_range(63),
                         $urandom_range(31), $urandom_range(255));
            else
            begin
                // short line, often touching the grid edges
                xs = ($urandom_range(3) == 0) ? 63 : $urandom_range(63);
                ys = $urandom_range(31);
                add_line(xs, ys, xs + $urandom_range(6) - 3, ys + $urandom_range(4) - 2,
                         $urandom_range(255));
            end
        end
    endtask

    task automatic wait_drained();
        while (line_requests.size() != 0 || lines_taken != lines_offered ||
               expected_points.size() != 0)
            @(posedge clk);
    endtask

    // request driver
    always @(negedge clk)
    begin : drive_requests
        line_req_t req;
        if (rst_n)
        begin
            if (s_axis_tvalid && lines_taken != lines_offered)
                ;  // request still waiting for tready
            else if (line_requests.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                req = line_requests.pop_front();
                s_axis_tdata  <= {2'b00, req.glyph, req.ye, req.xe, req.ys, req.xs};
                s_axis_tvalid <= 1'b1;
                lines_offered++;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
            m_axis_tready <= !rx_blocked && ($urandom_range(99) >= recv_idle_pct);
    end

    // monitor: predict on accepted requests, check every accepted point
    always @(posedge clk)
    begin : monitor
        line_req_t   req;
        cell_write_t got;
        cell_write_t exp;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                req.xs    = s_axis_tdata[5:0];
                req.ys    = s_axis_tdata[10:6];
                req.xe    = s_axis_tdata[16:11];
                req.ye    = s_axis_tdata[21:17];
                req.glyph = s_axis_tdata[29:22];
                trace_line(req);
                lines_taken++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.col   = m_axis_tdata[5:0];
                got.row   = m_axis_tdata[10:6];
                got.glyph = m_axis_tdata[18:11];
                got.right = m_axis_tuser;
                got.last  = m_axis_tlast;
                if (expected_points.size() == 0)
                begin
                    $display("%0t: point expected none got col %0d row %0d", $time,
                             got.col, got.row);
                    errors++;
                end
                else
                begin
                    exp = expected_points.pop_front();
                    if (got.col !== exp.col)
                    begin
                        $display("%0t: cell_col expected %0d got %0d", $time, exp.col, got.col);
                        errors++;
                    end
                    if (got.row !== exp.row)
                    begin
                        $display("%0t: cell_row expected %0d got %0d", $time, exp.row, got.row);
                        errors++;
                    end
                    if (got.glyph !== exp.glyph)
                    begin
                        $display("%0t: cell_glyph expected %0h got %0h", $time, exp.glyph,
                                 got.glyph);
                        errors++;
                    end
                    if (got.right !== exp.right)
                    begin
                        $display("%0t: also_right expected %0b got %0b", $time, exp.right,
                                 got.right);
                        errors++;
                    end
                    if (got.last !== exp.last)
                    begin
                        $display("%0t: last_point expected %0b got %0b", $time, exp.last,
                                 got.last);
                        errors++;
                    end
                end
            end
        end
    end

    // long output stall at the start of the last phase so the command queue backs up
    initial
    begin
        rx_blocked = 1'b0;
        wait (phase == 2);
        @(posedge clk);
        rx_blocked = 1'b1;
        repeat (400) @(posedge clk);
        rx_blocked = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("[bresenham_line_point_generator_top] ERROR");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        lines_offered = 0;
        lines_taken   = 0;
        errors        = 0;
        phase         = 0;
        send_idle_pct = 23;
        recv_idle_pct = 50;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // single points, corners, full spans, every octant, last column
        add_line(0, 0, 0, 0, 8'h00);
        add_line(63, 31, 63, 31, 8'hFF);
        add_line(0, 0, 63, 0, 8'hAA);
        add_line(63, 31, 0, 31, 8'h55);
        add_line(0, 0, 0, 31, 8'h01);
        add_line(63, 31, 63, 0, 8'h80);
        add_line(0, 0, 63, 31, 8'h7F);
        add_line(63, 0, 0, 31, 8'hFE);
        add_line(0, 31, 63, 0, 8'h41);
        add_line(63, 31, 0, 0, 8'h23);
        add_line(10, 5, 13, 20, 8'h2A);
        add_line(13, 20, 10, 5, 8'h2B);
        add_line(40, 3, 30, 25, 8'h2C);
        add_line(30, 25, 40, 3, 8'h2D);
        add_line(5, 5, 15, 15, 8'h2E);
        add_line(15, 5, 5, 15, 8'h2F);
        add_line(62, 10, 63, 12, 8'h30);
        add_line(63, 12, 62, 10, 8'h31);
        add_line(20, 7, 21, 7, 8'h32);
        add_line(21, 8, 20, 8, 8'h33);
        add_random_lines(70);
        wait_drained();

        phase         = 1;
        send_idle_pct = 50;
        recv_idle_pct = 23;
        add_random_lines(90);
        wait_drained();

        phase         = 2;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_random_lines(100);
        wait_drained();

        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("[bresenham_line_point_generator_top] OK");
        else
            $display("[bresenham_line_point_generator_top] ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
design/blpg_pkg.sv
design/blpg_front.sv
design/blpg_cmd_queue.sv
design/blpg_walker.sv
design/bresenham_line_point_generator_top.sv
design/blpg_checker.sv
tb/testbench.sv
